FILE: rtl/aes128_block_encrypt_assert.svh
// Assertion macros shared by the AES-128 encryption block.
// Included by the top level, the only module that carries concurrent assertions.
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define AES_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after the trigger.
`define AES_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("assertion failed");

`endif

FILE: rtl/aes_pkg.sv
// Package for the AES-128 encryption block: types, constants, S-box and round functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;
  localparam int unsigned NumRounds = 10;
  localparam int unsigned DataW     = 64;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned CfgIdxW   = 1;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

  typedef logic [BlockW-1:0] block_t;

  typedef struct packed {
    logic   vld;
    block_t st;
    block_t rk;
  } stage_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_b(input block_t b, input int unsigned i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    localparam int unsigned Perm [16] = '{0,5,10,15,4,9,14,3,8,13,2,7,12,1,6,11};
    block_t r;
    for (int i = 0; i < 16; i++) r[BlockW-1-8*i -: 8] = sbox(get_b(s, Perm[i]));
    return r;
  endfunction

  function automatic block_t mix(input block_t s);
    block_t r;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      r[BlockW-1-32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
      r[BlockW-9-32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      r[BlockW-17-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      r[BlockW-25-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return r;
  endfunction

  // Next round key from the previous one.
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    {w0, w1, w2, w3} = k;
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rcon(input int unsigned r);
    logic [7:0] v;
    v = 8'h01;
    for (int i = 1; i < 10; i++) if (i < r) v = xtime(v);
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/aes_round.sv
// One pipelined AES round: SubBytes/ShiftRows, optional MixColumns, key XOR, key step.
// Depends on aes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aes_round import aes_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic [7:0] rcon_i,
  input  wire logic       last_i,
  input  wire stage_t     in_i,
  output      stage_t     out_o
);
  logic   vld_q;
  block_t st_q, rk_q, key_d, st_d;

  always_comb begin
    key_d = next_key(in_i.rk, rcon_i);
    st_d  = sub_shift(in_i.st);
    if (!last_i) st_d = mix(st_d);
    st_d = st_d ^ key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
      rk_q <= key_d;
    end
  end

  assign out_o = '{vld: vld_q, st: st_q, rk: rk_q};
endmodule
`default_nettype wire

FILE: rtl/aes128_block_encrypt.sv
// Top level of the AES-128 encryption block: key registers, input stage, ten rounds.
// Depends on aes_pkg, aes_round and aes128_block_encrypt_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_encrypt_assert.svh"
// AES-128 (FIPS-197) encryption pipeline. One block enters per cycle while the output is not
// stalled; it passes an input stage for the initial key XOR, then one register stage per round
// in the ten unrolled rounds, each of which also derives its own round key on the fly.
// The whole pipeline advances together and holds when the output is stalled, so
// s_axis_tready follows m_axis_tready or an empty output slot. Write the key only
// while the pipeline is empty; it is sampled when a block enters.
module aes128_block_encrypt import aes_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [DataW-1:0]   cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [BlockW-1:0]  s_axis_tdata,  // plain_high [63:0], plain_low [127:64]
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [BlockW-1:0]  m_axis_tdata   // cipher_high [63:0], cipher_low [127:64]
);
  logic [DataW-1:0] key_hi_q, key_lo_q;
  logic   en;
  stage_t stg [NumRounds+1];
  logic   vld0_q;
  block_t st0_q, rk0_q;

  // Key registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeyHigh: key_hi_q <= cfg_wdata_i;
        RegKeyLow:  key_lo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the output holds an untaken item.
  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_axis_tvalid;
    end
  end

  // Initial key XOR; plain_high sits in the low half of tdata and carries byte 0 on top.
  always_ff @(posedge clk_i) begin
    if (en) begin
      st0_q <= {s_axis_tdata[DataW-1:0], s_axis_tdata[BlockW-1:DataW]}
               ^ {key_hi_q, key_lo_q};
      rk0_q <= {key_hi_q, key_lo_q};
    end
  end

  assign stg[0] = '{vld: vld0_q, st: st0_q, rk: rk0_q};

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rcon_i (rcon(r)),
      .last_i (r == NumRounds),
      .in_i   (stg[r-1]),
      .out_o  (stg[r])
    );
  end

  // Put cipher_high back into the low half of tdata.
  assign m_axis_tvalid = stg[NumRounds].vld;
  assign m_axis_tdata  = {stg[NumRounds].st[DataW-1:0], stg[NumRounds].st[BlockW-1:DataW]};

  // A stalled result holds.
  `AES_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // An accepted item reaches the first stage.
  `AES_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, vld0_q)
  // Input is taken whenever the output slot is free.
  `AES_ASSERT(a_ready, !m_axis_tvalid |-> s_axis_tready)
endmodule
`default_nettype wire

FILE: tb/aes128_block_encrypt_checker.sv
// Checker for the AES-128 encryption block: watches the key port and both streams,
// predicts each ciphertext and compares it. Depends on aes_pkg for widths and indexes.
`timescale 1ns / 1ps
module aes128_block_encrypt_checker import aes_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_idx_i,
  input logic [DataW-1:0]   cfg_wdata_i,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [BlockW-1:0]  s_axis_tdata,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [BlockW-1:0]  m_axis_tdata,
  output int                fail_cnt_o,
  output int                pending_o,
  output int                cipher_cnt_o
);
  localparam logic [7:0] SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };
  localparam int unsigned RowShift [16] = '{0,5,10,15,4,9,14,3,8,13,2,7,12,1,6,11};

  logic [DataW-1:0]  key_hi_q, key_lo_q;
  logic [BlockW-1:0] cipher_q [$];

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte-array form: byte 0 is the top byte of the high half.
  function automatic logic [BlockW-1:0] encrypt_block(input logic [BlockW-1:0] key,
                                                      input logic [BlockW-1:0] plain);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] f, rc, a0, a1, a2, a3, al;
    logic [BlockW-1:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[BlockW-1-8*i -: 8];
      s[i]  = plain[BlockW-1-8*i -: 8] ^ rk[i];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
      if ((i % 4) == 0) begin
        f = w[0];
        w[0] = SboxTab[w[1]] ^ rc;
        w[1] = SboxTab[w[2]];
        w[2] = SboxTab[w[3]];
        w[3] = SboxTab[f];
        rc = gf_dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) t[i] = SboxTab[s[RowShift[i]]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[BlockW-1-8*i -: 8] = s[i];
    return res;
  endfunction

  assign pending_o = cipher_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [BlockW-1:0] want;
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      fail_cnt_o <= 0;
      cipher_cnt_o <= 0;
      cipher_q.delete();
    end else begin
      // Blocks sample the key as it stands before this edge's write.
      // plain_high travels in the low half of tdata.
      if (s_axis_tvalid && s_axis_tready)
        cipher_q.push_back(encrypt_block({key_hi_q, key_lo_q},
                                         {s_axis_tdata[63:0], s_axis_tdata[127:64]}));
      if (cfg_we_i) begin
        if (cfg_idx_i == RegKeyHigh) key_hi_q <= cfg_wdata_i;
        else if (cfg_idx_i == RegKeyLow) key_lo_q <= cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        cipher_cnt_o <= cipher_cnt_o + 1;
        if (cipher_q.size() == 0) begin
          $error("unexpected ciphertext %h", m_axis_tdata);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = cipher_q.pop_front();
          if (want[127:64] !== m_axis_tdata[63:0] || want[63:0] !== m_axis_tdata[127:64]) begin
            if (want[127:64] !== m_axis_tdata[63:0])
              $error("cipher_high: expected %h, got %h", want[127:64], m_axis_tdata[63:0]);
            if (want[63:0] !== m_axis_tdata[127:64])
              $error("cipher_low: expected %h, got %h", want[63:0], m_axis_tdata[127:64]);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/tb_top.sv
// Testbench top for the AES-128 encryption block: clock, reset, key writes and block stimulus.
// Depends on aes_pkg, aes128_block_encrypt and aes128_block_encrypt_checker.
`timescale 1ns / 1ps
module tb_top;
  import aes_pkg::*;

  localparam int Latency = 11;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegKeyHigh;
  logic [DataW-1:0]   cfg_wdata_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [BlockW-1:0]  s_axis_tdata = '0;  // plain_high [63:0], plain_low [127:64]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [BlockW-1:0]  m_axis_tdata;       // cipher_high [63:0], cipher_low [127:64]
  int                 fail_cnt, pending, cipher_cnt;
  int                 stall_mode;
  int                 block_cnt;
  int                 key_cnt;

  aes128_block_encrypt u_dut (.*);

  aes128_block_encrypt_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .cipher_cnt_o(cipher_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: cycle through free flow, light, heavy and long stalls.
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      n = $urandom_range(0, 99);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= (n < 80);
        2: m_axis_tready <= (n < 30);
        default: m_axis_tready <= (n < 5);
      endcase
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    end
  end

  // Present one block and hold it until accepted; the next one follows without dropping valid.
  task automatic send_block(input logic [DataW-1:0] hi, input logic [DataW-1:0] lo);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lo, hi};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    block_cnt++;
  endtask

  task automatic go_idle(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Wait for the pipeline to drain, then let the latency pass before a key write.
  task automatic drain;
    go_idle(1);
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 2) @(negedge clk_i);
  endtask

  task automatic write_key(input logic [DataW-1:0] hi, input logic [DataW-1:0] lo);
    cfg_we_i <= 1'b1; cfg_idx_i <= RegKeyHigh; cfg_wdata_i <= hi;
    @(negedge clk_i);
    cfg_idx_i <= RegKeyLow; cfg_wdata_i <= lo;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    key_cnt++;
  endtask

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random-content half of a block, occasionally all zero, all ones or a single set bit.
  function automatic logic [DataW-1:0] rand_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return DataW'(1) << $urandom_range(0, DataW - 1);
      default: return rand64();
    endcase
  endfunction

  task automatic random_phase(input int count);
    int left;
    left = count;
    while (left > 0) begin
      // Burst of back-to-back blocks, then a gap (sometimes none).
      for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
        send_block(rand_half(), rand_half());
        left--;
      end
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 8));
    end
  endtask

  initial begin
    stall_mode = 0;
    block_cnt = 0;
    key_cnt = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset key (all zero): extremes, a block with only its top and bottom bits set, alternating bits.
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    drain();

    // Standard test vector key, then the all-ones key.
    write_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block('0, '0);
    send_block('1, '1);
    drain();
    write_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    drain();

    // Write only one half of the key: the other half must be retained.
    cfg_we_i <= 1'b1; cfg_idx_i <= RegKeyLow; cfg_wdata_i <= '0;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_block('0, '1);
    drain();

    // Random phases under fresh keys; stall patterns vary inside each.
    for (int ph = 0; ph < 6; ph++) begin
      write_key(rand64(), rand64());
      stall_mode = ph % 4;
      random_phase(150);
      if (ph == 2) drain();  // pause the sender until every ciphertext is out
      else begin
        go_idle(1);
        drain();
      end
    end
    write_key('0, '0);
    random_phase(20);
    drain();

    $display("Run covered %0d blocks under %0d key settings, %0d ciphertexts checked.",
             block_cnt, key_cnt + 1, cipher_cnt);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5ms;
    $display("Timeout: sent %0d, received %0d", block_cnt, cipher_cnt);
    $display("Some tests failed");
    $finish;
  end
endmodule

FILE: aes128_block_encrypt.f
+incdir+rtl
rtl/aes_pkg.sv
rtl/aes_round.sv
rtl/aes128_block_encrypt.sv
tb/aes128_block_encrypt_checker.sv
tb/tb_top.sv
